>>> rtl/srm_pkg.sv
package srm_pkg;

  localparam int unsigned MAX_SAMPLES  = 65536;
  localparam int unsigned SAMPLE_WIDTH = 16;

  localparam int unsigned RMS_WIDTH   = 16;
  localparam int unsigned COUNT_OUT_W = 17;

  localparam int unsigned COUNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SUM_FULL = 2 * SAMPLE_WIDTH - 2 + $clog2(MAX_SAMPLES) + 1;
  localparam int unsigned SUM_W    = (SUM_FULL > 64) ? 64 : SUM_FULL;
  localparam int unsigned PROD_W   = 2 * SAMPLE_WIDTH;
  localparam int unsigned ROOT_W   = SAMPLE_WIDTH;
  localparam int unsigned RAD_W    = 2 * ROOT_W;
  localparam int unsigned ALU_W    = (COUNT_W + 1 > ROOT_W + 2) ? COUNT_W + 1 : ROOT_W + 2;
  localparam int unsigned STEP_W   = $clog2(SUM_W);

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           last;
  } in_t;

  typedef struct packed {
    logic [RMS_WIDTH-1:0]   rms_value;
    logic [COUNT_OUT_W-1:0] sample_count;
    logic                   count_overflow;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_DIVIDE,
    ST_ROOT
  } state_e;

endpackage

>>> rtl/signal_rms_meter_core.sv
// Channel    Direction  Handshake                    Payload
// input      in         start_i high, busy_o low     in_i     (srm_pkg::in_t)
// result     out        result_valid_o, one cycle    result_o (srm_pkg::out_t)
//
// A sample that does not close a block is captured, squared and accumulated in turn.
// The closing sample then goes on through the divide and the root: one shared
// subtractor runs a restoring divide, one quotient bit per cycle, then a digit-by-digit
// square root, one root bit per cycle. The result strobes in the cycle busy_o drops.
// rst_ni clears the sum, count, overflow flag and sequencer. The receiver cannot stall.
module signal_rms_meter_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  srm_pkg::in_t  in_i,
  output logic          result_valid_o,
  output srm_pkg::out_t result_o
);
  import srm_pkg::*;

  state_e state_q, state_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [COUNT_W-1:0] count_q, count_d;
  logic               ovf_q, ovf_d;
  logic               valid_q, valid_d;

  logic signed [SAMPLE_WIDTH-1:0] smp_q, smp_d;
  logic                 last_q, last_d;
  logic [PROD_W-1:0]    prod_q, prod_d;
  logic [SUM_W-1:0]     x_q, x_d;
  logic [ALU_W-1:0]     rem_q, rem_d;
  logic [ROOT_W-1:0]    root_q, root_d;
  out_t                 res_q, res_d;

  logic [SAMPLE_WIDTH-1:0] mag;
  logic [SUM_W-1:0]        sum_acc;
  logic [ALU_W-1:0]        alu_a, alu_b;
  logic [ALU_W:0]          alu_diff;
  logic                    borrow;

  assign mag      = smp_q[SAMPLE_WIDTH-1] ? $unsigned(-smp_q) : $unsigned(smp_q);
  assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
  assign borrow   = alu_diff[ALU_W];

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    sum_d   = sum_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    valid_d = 1'b0;
    smp_d   = smp_q;
    last_d  = last_q;
    prod_d  = prod_q;
    x_d     = x_q;
    rem_d   = rem_q;
    root_d  = root_q;
    res_d   = res_q;
    alu_a   = '0;
    alu_b   = '0;
    sum_acc = sum_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          smp_d   = in_i.sample;
          last_d  = in_i.last;
          state_d = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        prod_d  = {{SAMPLE_WIDTH{1'b0}}, mag} * {{SAMPLE_WIDTH{1'b0}}, mag};
        state_d = ST_ACCUM;
      end
      ST_ACCUM: begin
        if (count_q == COUNT_W'(MAX_SAMPLES)) begin
          ovf_d = 1'b1;
        end else begin
          sum_acc = sum_q + SUM_W'(prod_q);
          count_d = count_q + 1'b1;
        end
        if (last_q) begin
          x_d     = sum_acc;
          sum_d   = '0;
          rem_d   = '0;
          step_d  = STEP_W'(SUM_W - 1);
          state_d = ST_DIVIDE;
        end else begin
          sum_d   = sum_acc;
          state_d = ST_IDLE;
        end
      end
      ST_DIVIDE: begin
        alu_a = {rem_q[ALU_W-2:0], x_q[SUM_W-1]};
        alu_b = ALU_W'(count_q);
        x_d   = {x_q[SUM_W-2:0], ~borrow};
        rem_d = borrow ? alu_a : alu_diff[ALU_W-1:0];
        if (step_q == '0) begin
          rem_d   = '0;
          root_d  = '0;
          step_d  = STEP_W'(ROOT_W - 1);
          state_d = ST_ROOT;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      ST_ROOT: begin
        alu_a  = {rem_q[ALU_W-3:0], x_q[RAD_W-1 -: 2]};
        alu_b  = ALU_W'({root_q, 2'b01});
        root_d = {root_q[ROOT_W-2:0], ~borrow};
        rem_d  = borrow ? alu_a : alu_diff[ALU_W-1:0];
        x_d    = {x_q[SUM_W-3:0], 2'b00};
        if (step_q == '0) begin
          res_d.rms_value      = RMS_WIDTH'(root_d);
          res_d.sample_count   = COUNT_OUT_W'(count_q);
          res_d.count_overflow = ovf_q;
          valid_d = 1'b1;
          count_d = '0;
          ovf_d   = 1'b0;
          state_d = ST_IDLE;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      sum_q   <= '0;
      count_q <= '0;
      ovf_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      sum_q   <= sum_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    smp_q  <= smp_d;
    last_q <= last_d;
    prod_q <= prod_d;
    x_q    <= x_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    res_q  <= res_d;
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = valid_q;
  assign result_o       = res_q;

endmodule
